FILE: sv/heating_curve_interpolator_defines.svh
// Assertion helpers shared by the checker.
`ifndef HEATING_CURVE_INTERPOLATOR_DEFINES_SVH
`define HEATING_CURVE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HCI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hci_pkg.sv
`default_nettype none
package hci_pkg;

  localparam int MAX_POINTS = 8;
  localparam int MIN_POINTS = 2;

  localparam int TEMP_W     = 10;
  localparam int SP_W       = 10;
  localparam int CNT_W      = 4;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int PT_W       = TEMP_W + 2 * SP_W;
  localparam int PT_AW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int N_W        = $clog2(MAX_POINTS + 1);
  localparam int PROD_W     = 2 * SP_W;
  localparam int DIV_CW     = $clog2(PROD_W);

  localparam logic [SP_W-1:0] RST_DEFAULT_FLOW   = SP_W'(450);
  localparam logic [SP_W-1:0] RST_DEFAULT_RETURN = SP_W'(350);

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT    = 2'd0,
    CFG_DEFAULT_FLOW   = 2'd1,
    CFG_DEFAULT_RETURN = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_CHK_LO,
    ST_CHK_HI,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [SP_W-1:0]          flow;
    logic [SP_W-1:0]          ret;
  } point_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] num_f;
    logic [PROD_W-1:0] num_r;
    logic [SP_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [SP_W-1:0] q_f;
    logic [SP_W-1:0] q_r;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/heating_curve_interpolator.sv
// Results: the default result when the table holds fewer than MIN_POINTS points, a
// clamped result outside the table's range, else an interpolated result, found by the
// point walk over the table RAM (one entry per cycle) and the 20-step serial divider.
// One query in flight, the next taken in the cycle after its result loads;
// point writes are taken back to back and give no result.
// Reset (rst_n low, synchronous): point_count 0, defaults 450/350, no result.
`default_nettype none
module heating_curve_interpolator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_func,
  input  wire logic [hci_pkg::IDX_W-1:0]           in_point_index,
  input  wire logic signed [hci_pkg::TEMP_W-1:0]   in_outside_temp,
  input  wire logic [hci_pkg::SP_W-1:0]            in_flow_setpoint,
  input  wire logic [hci_pkg::SP_W-1:0]            in_return_setpoint,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [hci_pkg::SP_W-1:0]                 out_flow_out,
  output logic [hci_pkg::SP_W-1:0]                 out_return_out,
  output logic                                     out_used_default,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hci_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [hci_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hci_pkg::*;

  logic [CNT_W-1:0] point_count_r;
  logic [SP_W-1:0]  default_flow_r, default_return_r;
  logic             ram_we, ram_re;
  logic [PT_AW-1:0] ram_waddr, ram_raddr;
  point_t           ram_wdata, ram_rdata;
  logic [PT_W-1:0]  ram_rdata_raw;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign cfg_ready = 1'b1;
  assign ram_rdata = point_t'(ram_rdata_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r    <= '0;
      default_flow_r   <= RST_DEFAULT_FLOW;
      default_return_r <= RST_DEFAULT_RETURN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POINT_COUNT:    point_count_r    <= cfg_data[CNT_W-1:0];
        CFG_DEFAULT_FLOW:   default_flow_r   <= cfg_data[SP_W-1:0];
        CFG_DEFAULT_RETURN: default_return_r <= cfg_data[SP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  hci_ram #(
    .WIDTH(PT_W),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (PT_W'(ram_wdata)),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  hci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  hci_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_point_index     (in_point_index),
    .in_outside_temp    (in_outside_temp),
    .in_flow_setpoint   (in_flow_setpoint),
    .in_return_setpoint (in_return_setpoint),
    .point_count        (point_count_r),
    .default_flow       (default_flow_r),
    .default_return     (default_return_r),
    .ram_we             (ram_we),
    .ram_waddr          (ram_waddr),
    .ram_wdata          (ram_wdata),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_flow_out       (out_flow_out),
    .out_return_out     (out_return_out),
    .out_used_default   (out_used_default)
  );

endmodule
`default_nettype wire

FILE: sv/hci_ram.sv
`default_nettype none
module hci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/hci_div.sv
`default_nettype none
module hci_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hci_pkg::div_req_t req,
  output hci_pkg::div_rsp_t      rsp
);
  import hci_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [PROD_W-1:0] qf_r, qf_nxt, qr_r, qr_nxt;
  logic [SP_W:0]     remf_r, remf_nxt, remr_r, remr_nxt;
  logic [SP_W-1:0]   den_r, den_nxt;
  logic [SP_W:0]     shf, shr;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    qf_nxt   = qf_r;
    qr_nxt   = qr_r;
    remf_nxt = remf_r;
    remr_nxt = remr_r;
    den_nxt  = den_r;
    shf      = {remf_r[SP_W-1:0], qf_r[PROD_W-1]};
    shr      = {remr_r[SP_W-1:0], qr_r[PROD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      qf_nxt   = req.num_f;
      qr_nxt   = req.num_r;
      remf_nxt = '0;
      remr_nxt = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      qf_nxt = {qf_r[PROD_W-2:0], 1'b0};
      qr_nxt = {qr_r[PROD_W-2:0], 1'b0};
      if (shf >= {1'b0, den_r}) begin
        remf_nxt  = shf - {1'b0, den_r};
        qf_nxt[0] = 1'b1;
      end else begin
        remf_nxt = shf;
      end
      if (shr >= {1'b0, den_r}) begin
        remr_nxt  = shr - {1'b0, den_r};
        qr_nxt[0] = 1'b1;
      end else begin
        remr_nxt = shr;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(PROD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    qf_r   <= qf_nxt;
    qr_r   <= qr_nxt;
    remf_r <= remf_nxt;
    remr_r <= remr_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.q_f  = qf_r[SP_W-1:0];
  assign rsp.q_r  = qr_r[SP_W-1:0];

endmodule
`default_nettype wire

FILE: sv/hci_ctrl.sv
`default_nettype none
module hci_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_func,
  input  wire logic [hci_pkg::IDX_W-1:0]           in_point_index,
  input  wire logic signed [hci_pkg::TEMP_W-1:0]   in_outside_temp,
  input  wire logic [hci_pkg::SP_W-1:0]            in_flow_setpoint,
  input  wire logic [hci_pkg::SP_W-1:0]            in_return_setpoint,
  input  wire logic [hci_pkg::CNT_W-1:0]           point_count,
  input  wire logic [hci_pkg::SP_W-1:0]            default_flow,
  input  wire logic [hci_pkg::SP_W-1:0]            default_return,
  output logic                                     ram_we,
  output logic [hci_pkg::PT_AW-1:0]                ram_waddr,
  output hci_pkg::point_t                          ram_wdata,
  output logic                                     ram_re,
  output logic [hci_pkg::PT_AW-1:0]                ram_raddr,
  input  wire hci_pkg::point_t                     ram_rdata,
  output hci_pkg::div_req_t                        div_req,
  input  wire hci_pkg::div_rsp_t                   div_rsp,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [hci_pkg::SP_W-1:0]                 out_flow_out,
  output logic [hci_pkg::SP_W-1:0]                 out_return_out,
  output logic                                     out_used_default
);
  import hci_pkg::*;

  state_t                   state_r, state_nxt;
  logic signed [TEMP_W-1:0] x_r, x_nxt;
  logic [N_W-1:0]           n_r, n_nxt;
  logic [N_W-1:0]           n_cur;
  logic [PT_AW-1:0]         idx_r, idx_nxt;
  logic [PT_AW-1:0]         last;
  point_t                   prev_r, prev_nxt;
  logic [SP_W-1:0]          dx_r, dx_nxt, den_r, den_nxt;
  logic [SP_W-1:0]          magf_r, magf_nxt, magr_r, magr_nxt;
  logic                     negf_r, negf_nxt, negr_r, negr_nxt;
  logic [SP_W-1:0]          y0f_r, y0f_nxt, y0r_r, y0r_nxt;
  logic [SP_W-1:0]          resf_r, resf_nxt, resr_r, resr_nxt;
  logic                     resd_r, resd_nxt;
  logic                     ov_r, ov_nxt;
  logic [SP_W-1:0]          of_r, of_nxt, or_r, or_nxt;
  logic                     od_r, od_nxt;
  logic                     in_acc;
  logic signed [TEMP_W:0]   dx_full, den_full;
  logic signed [SP_W:0]     dyf, dyr;

  assign in_acc = in_valid && !in_stall;
  assign n_cur  = (int'(point_count) > MAX_POINTS) ? N_W'(MAX_POINTS) : N_W'(point_count);
  assign last   = PT_AW'(n_r - 1'b1);

  assign dx_full  = {x_r[TEMP_W-1], x_r} - {prev_r.temp[TEMP_W-1], prev_r.temp};
  assign den_full = {ram_rdata.temp[TEMP_W-1], ram_rdata.temp}
                    - {prev_r.temp[TEMP_W-1], prev_r.temp};
  assign dyf      = {1'b0, ram_rdata.flow} - {1'b0, prev_r.flow};
  assign dyr      = {1'b0, ram_rdata.ret} - {1'b0, prev_r.ret};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    n_r    <= n_nxt;
    idx_r  <= idx_nxt;
    prev_r <= prev_nxt;
    dx_r   <= dx_nxt;
    den_r  <= den_nxt;
    magf_r <= magf_nxt;
    magr_r <= magr_nxt;
    negf_r <= negf_nxt;
    negr_r <= negr_nxt;
    y0f_r  <= y0f_nxt;
    y0r_r  <= y0r_nxt;
    resf_r <= resf_nxt;
    resr_r <= resr_nxt;
    resd_r <= resd_nxt;
    of_r   <= of_nxt;
    or_r   <= or_nxt;
    od_r   <= od_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    prev_nxt  = prev_r;
    dx_nxt    = dx_r;
    den_nxt   = den_r;
    magf_nxt  = magf_r;
    magr_nxt  = magr_r;
    negf_nxt  = negf_r;
    negr_nxt  = negr_r;
    y0f_nxt   = y0f_r;
    y0r_nxt   = y0r_r;
    resf_nxt  = resf_r;
    resr_nxt  = resr_r;
    resd_nxt  = resd_r;
    of_nxt    = of_r;
    or_nxt    = or_r;
    od_nxt    = od_r;
    ov_nxt    = ov_r && out_stall;

    in_stall  = (state_r != ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = PT_AW'(in_point_index);
    ram_wdata = '{temp: in_outside_temp, flow: in_flow_setpoint, ret: in_return_setpoint};
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    div_req.start = 1'b0;
    div_req.num_f = magf_r * dx_r;
    div_req.num_r = magr_r * dx_r;
    div_req.den   = den_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (func_t'(in_func) == FUNC_WRITE) begin
            ram_we = (int'(in_point_index) < MAX_POINTS);
          end else begin
            x_nxt    = in_outside_temp;
            n_nxt    = n_cur;
            resf_nxt = default_flow;
            resr_nxt = default_return;
            resd_nxt = 1'b1;
            if (int'(n_cur) < MIN_POINTS) begin
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_RD_LO;
            end
          end
        end
      end
      ST_RD_LO: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_nxt = ST_CHK_LO;
      end
      ST_CHK_LO: begin
        prev_nxt = ram_rdata;
        if (x_r <= ram_rdata.temp) begin
          resf_nxt  = ram_rdata.flow;
          resr_nxt  = ram_rdata.ret;
          resd_nxt  = 1'b0;
          state_nxt = ST_RESULT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = last;
          state_nxt = ST_CHK_HI;
        end
      end
      ST_CHK_HI: begin
        if (x_r >= ram_rdata.temp) begin
          resf_nxt  = ram_rdata.flow;
          resr_nxt  = ram_rdata.ret;
          resd_nxt  = 1'b0;
          state_nxt = ST_RESULT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = PT_AW'(1);
          idx_nxt   = PT_AW'(1);
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (x_r >= prev_r.temp && x_r <= ram_rdata.temp) begin
          resd_nxt = 1'b0;
          if (ram_rdata.temp == prev_r.temp) begin
            resf_nxt  = prev_r.flow;
            resr_nxt  = prev_r.ret;
            state_nxt = ST_RESULT;
          end else begin
            dx_nxt    = dx_full[SP_W-1:0];
            den_nxt   = den_full[SP_W-1:0];
            negf_nxt  = dyf[SP_W];
            negr_nxt  = dyr[SP_W];
            magf_nxt  = dyf[SP_W] ? SP_W'(-dyf) : dyf[SP_W-1:0];
            magr_nxt  = dyr[SP_W] ? SP_W'(-dyr) : dyr[SP_W-1:0];
            y0f_nxt   = prev_r.flow;
            y0r_nxt   = prev_r.ret;
            state_nxt = ST_MUL;
          end
        end else if (idx_r == last) begin
          state_nxt = ST_RESULT;
        end else begin
          prev_nxt  = ram_rdata;
          idx_nxt   = idx_r + 1'b1;
          ram_re    = 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          resf_nxt  = negf_r ? (y0f_r - div_rsp.q_f) : (y0f_r + div_rsp.q_f);
          resr_nxt  = negr_r ? (y0r_r - div_rsp.q_r) : (y0r_r + div_rsp.q_r);
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          of_nxt    = resf_r;
          or_nxt    = resr_r;
          od_nxt    = resd_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = ov_r;
  assign out_flow_out     = of_r;
  assign out_return_out   = or_r;
  assign out_used_default = od_r;

endmodule
`default_nettype wire

FILE: sv/hci_checker.sv
`default_nettype none
`include "heating_curve_interpolator_defines.svh"
module hci_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic in_func,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [hci_pkg::SP_W-1:0] out_flow_out,
  input wire logic [hci_pkg::SP_W-1:0] out_return_out,
  input wire logic out_used_default,
  input wire logic cfg_valid,
  input wire logic cfg_ready
);
  import hci_pkg::*;

  `HCI_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_flow_out) && $stable(out_return_out)
    && $stable(out_used_default), "result changed while stalled")

  `HCI_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && in_func == FUNC_QUERY,
    in_stall, "transaction accepted while a query is in flight")

  `HCI_ASSERT_NEXT(a_write_silent,
    in_valid && !in_stall && in_func == FUNC_WRITE && !out_valid,
    !out_valid, "point write produced a result")

  `HCI_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write not taken")

endmodule

bind heating_curve_interpolator hci_checker u_hci_checker (.*);
`default_nettype wire
